// File: sv/hgv_pkg.sv
// Package: byte codes, outcome codes, parser state type and per-byte update functions.
`default_nettype none
package hgv_pkg;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_COLON = 8'd58;

  localparam logic [1:0] PH_REQ    = 2'd0;
  localparam logic [1:0] PH_HDR    = 2'd1;
  localparam logic [1:0] PH_IGNORE = 2'd2;

  localparam logic [2:0] OUT_OK       = 3'd0;
  localparam logic [2:0] OUT_BAD_LINE = 3'd1;
  localparam logic [2:0] OUT_NOT_GET  = 3'd2;
  localparam logic [2:0] OUT_NO_COLON = 3'd3;
  localparam logic [2:0] OUT_NO_HOST  = 3'd4;

  localparam logic [2:0] METHOD_LEN = 3'd3;
  localparam logic [2:0] METHOD_OVF = 3'd4;
  localparam logic [2:0] KEY_LEN    = 3'd4;
  localparam logic [2:0] KEY_OVF    = 3'd5;

  typedef struct packed {
    logic [1:0] phase;
    logic       pending_cr;
    logic       line_nonempty;
    logic [1:0] spaces_seen;
    logic [2:0] method_pos;
    logic       method_match;
    logic       colon_seen;
    logic [2:0] key_pos;
    logic       key_match;
    logic       host_seen;
    logic [2:0] first_error;
  } hgv_state_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] outcome;
  } hgv_result_t;

  localparam hgv_state_t ST_RESET = '{
    phase:         PH_REQ,
    pending_cr:    1'b0,
    line_nonempty: 1'b0,
    spaces_seen:   2'd0,
    method_pos:    3'd0,
    method_match:  1'b1,
    colon_seen:    1'b0,
    key_pos:       3'd0,
    key_match:     1'b1,
    host_seen:     1'b0,
    first_error:   OUT_OK
  };

  function automatic logic [7:0] method_char(input logic [1:0] pos);
    case (pos)
      2'd0:    method_char = 8'h47;
      2'd1:    method_char = 8'h45;
      default: method_char = 8'h54;
    endcase
  endfunction

  function automatic logic [7:0] key_char(input logic [1:0] pos);
    case (pos)
      2'd0:    key_char = 8'h48;
      2'd1:    key_char = 8'h4F;
      2'd2:    key_char = 8'h53;
      default: key_char = 8'h54;
    endcase
  endfunction

  function automatic hgv_state_t take_char(input hgv_state_t s, input logic [7:0] c);
    hgv_state_t t;
    t = s;
    if (s.phase == PH_REQ) begin
      t.line_nonempty = 1'b1;
      if (s.spaces_seen == 2'd0) begin
        if (c == CH_SP) begin
          t.spaces_seen = 2'd1;
        end else if (s.method_pos < METHOD_LEN) begin
          if (c != method_char(s.method_pos[1:0])) t.method_match = 1'b0;
          t.method_pos = s.method_pos + 3'd1;
        end else begin
          t.method_match = 1'b0;
          t.method_pos   = METHOD_OVF;
        end
      end else if (c == CH_SP && s.spaces_seen == 2'd1) begin
        t.spaces_seen = 2'd2;
      end
    end else if (s.phase == PH_HDR) begin
      t.line_nonempty = 1'b1;
      if (!s.colon_seen) begin
        if (c == CH_COLON) begin
          t.colon_seen = 1'b1;
          if (s.key_match && s.key_pos == KEY_LEN) t.host_seen = 1'b1;
        end else if (s.key_pos < KEY_LEN) begin
          if (c != key_char(s.key_pos[1:0])) t.key_match = 1'b0;
          t.key_pos = s.key_pos + 3'd1;
        end else begin
          t.key_match = 1'b0;
          t.key_pos   = KEY_OVF;
        end
      end
    end
    return t;
  endfunction

  function automatic hgv_state_t end_line(input hgv_state_t s);
    hgv_state_t t;
    t = s;
    if (s.phase == PH_REQ) begin
      if (!s.line_nonempty || s.spaces_seen < 2'd2) begin
        t.first_error = OUT_BAD_LINE;
      end else if (!(s.method_match && s.method_pos == METHOD_LEN)) begin
        t.first_error = OUT_NOT_GET;
      end else begin
        t.phase = PH_HDR;
      end
    end else if (s.phase == PH_HDR) begin
      if (!s.line_nonempty) t.phase = PH_IGNORE;
      else if (!s.colon_seen) t.first_error = OUT_NO_COLON;
    end
    t.line_nonempty = 1'b0;
    t.colon_seen    = 1'b0;
    t.key_pos       = 3'd0;
    t.key_match     = 1'b1;
    return t;
  endfunction

endpackage
`default_nettype wire

// File: sv/hgv_core.sv
// Parser state register and one-word update logic producing the verdict on the last word.
`default_nettype none
module hgv_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic [7:0]           byte_in,
  input  wire logic                 last,
  output hgv_pkg::hgv_result_t      result
);
  import hgv_pkg::*;

  hgv_state_t st_r;
  hgv_state_t st_nxt;
  hgv_state_t s_word;
  hgv_state_t s;

  always_comb begin
    s_word = st_r;
    if (st_r.first_error == OUT_OK && st_r.phase != PH_IGNORE) begin
      if (byte_in == CH_CR) begin
        if (st_r.pending_cr) s_word = take_char(s_word, CH_CR);
        s_word.pending_cr = 1'b1;
      end else if (byte_in == CH_LF && st_r.pending_cr) begin
        s_word.pending_cr = 1'b0;
        s_word = end_line(s_word);
      end else begin
        if (st_r.pending_cr) begin
          s_word = take_char(s_word, CH_CR);
          s_word.pending_cr = 1'b0;
        end
        s_word = take_char(s_word, byte_in);
      end
    end
  end

  always_comb begin
    s = s_word;
    if (s.first_error == OUT_OK && s.phase != PH_IGNORE) begin
      if (s.pending_cr) begin
        s = take_char(s, CH_CR);
        s.pending_cr = 1'b0;
      end
      if (s.line_nonempty) s = end_line(s);
    end
    if (s.first_error == OUT_OK && !s.host_seen) s.first_error = OUT_NO_HOST;
    result.outcome  = s.first_error;
    result.accepted = (s.first_error == OUT_OK);
  end

  always_comb begin
    st_nxt = st_r;
    if (step) begin
      if (last) st_nxt = ST_RESET;
      else st_nxt = s_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else begin
      st_r <= st_nxt;
    end
  end

  property p_reset_after_last;
    @(posedge clk) disable iff (!rst_n) (step && last) |=> (st_r == ST_RESET);
  endproperty
  a_reset_after_last: assert property (p_reset_after_last)
    else $error("parser state not cleared after last word");

  property p_error_sticky;
    @(posedge clk) disable iff (!rst_n)
      (step && !last && st_r.first_error != OUT_OK) |=>
        (st_r.first_error == $past(st_r.first_error));
  endproperty
  a_error_sticky: assert property (p_error_sticky)
    else $error("first error changed within a request");

  property p_hold_idle;
    @(posedge clk) disable iff (!rst_n) !step |=> $stable(st_r);
  endproperty
  a_hold_idle: assert property (p_hold_idle)
    else $error("parser state changed without a word");

endmodule
`default_nettype wire

// File: sv/http_get_request_validator.sv
// Top level: input word register, parser core and verdict output register.
// Path: the last byte is held in the input register until it can go on, and its verdict is then
// loaded into the result register (input register, then result register).
// Throughput: one byte per cycle; input stalls only while a last byte waits behind a
// verdict held in the full output register.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to the request line.
`default_nettype none
module http_get_request_validator (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte_in,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_accepted,
  output logic [2:0]      out_outcome
);
  import hgv_pkg::*;

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        s1_go;
  logic        in_take;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        res_load;
  hgv_result_t res;
  hgv_result_t res_r;

  assign s1_go    = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;
  assign res_load = s1_go && s1_last_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) s1_valid_nxt = 1'b1;
    else if (s1_go) s1_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_byte_in;
      s1_last_r <= in_last;
    end
    if (res_load) res_r <= res;
  end

  hgv_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_go),
    .byte_in (s1_byte_r),
    .last    (s1_last_r),
    .result  (res)
  );

  assign out_valid    = out_valid_r;
  assign out_accepted = res_r.accepted;
  assign out_outcome  = res_r.outcome;

  property p_verdict_source;
    @(posedge clk) disable iff (!rst_n) $rose(out_valid_r) |-> $past(res_load);
  endproperty
  a_verdict_source: assert property (p_verdict_source)
    else $error("verdict raised without a last word");

  property p_accept_code;
    @(posedge clk) disable iff (!rst_n) out_valid_r |-> (out_accepted == (out_outcome == OUT_OK));
  endproperty
  a_accept_code: assert property (p_accept_code)
    else $error("accepted flag disagrees with outcome");

  property p_no_overwrite;
    @(posedge clk) disable iff (!rst_n) (out_valid_r && out_stall) |-> !res_load;
  endproperty
  a_no_overwrite: assert property (p_no_overwrite)
    else $error("held verdict overwritten");

endmodule
`default_nettype wire

// File: test/http_get_request_validator_tb.sv
// Testbench for http_get_request_validator: directed and random requests checked against a predictor.
module http_get_request_validator_tb;
  import hgv_pkg::*;

  localparam int PREDICT = -1;
  localparam logic [23:0] GET_TEXT = "GET";
  localparam logic [31:0] HOST_TEXT = "HOST";

  typedef struct packed {
    logic       accepted;
    logic [2:0] outcome;
  } verdict_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte_in;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic       out_accepted;
  logic [2:0] out_outcome;

  http_get_request_validator i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte_in   (in_byte_in),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_accepted (out_accepted),
    .out_outcome  (out_outcome)
  );

  string dir_text [8] = '{
    "\r\n",
    "\377",
    "A  ",
    "GET  \r\nX",
    "GET  \r",
    "GET\r  \r\nHOST:",
    "GET  \r\nHOST:\r\n\r\nz",
    "GET  \r\nHost:"
  };
  int dir_code [8] = '{
    OUT_BAD_LINE, OUT_BAD_LINE, OUT_NOT_GET, OUT_NO_COLON, OUT_NO_HOST,
    PREDICT, OUT_OK, PREDICT
  };

  // parser state as the predictor sees it
  logic [1:0] ps_phase;
  logic       ps_cr;
  logic       ps_text;
  logic [1:0] ps_spaces;
  logic [2:0] ps_mlen;
  logic       ps_mok;
  logic       ps_colon;
  logic [2:0] ps_klen;
  logic       ps_kok;
  logic       ps_host;
  logic [2:0] ps_err;

  verdict_t   pending_verdicts [$];
  logic [7:0] request_bytes [$];
  string      key_pool = "HOSTGEhx-";

  int errors;
  int bytes_sent;
  int requests_sent;
  int rnd_req;
  int hold_off_cycles;
  int rx_len;
  bit steady;
  int outcome_seen [5];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("http_get_request_validator_tb failed");
    $finish;
  end

  task clear_parser();
    ps_phase  = PH_REQ;
    ps_cr     = 1'b0;
    ps_spaces = 2'd0;
    ps_mlen   = 3'd0;
    ps_mok    = 1'b1;
    ps_host   = 1'b0;
    ps_err    = OUT_OK;
    ps_text   = 1'b0;
    ps_colon  = 1'b0;
    ps_klen   = 3'd0;
    ps_kok    = 1'b1;
  endtask

  task absorb_char(input logic [7:0] c);
    if (ps_phase == PH_REQ) begin
      ps_text = 1'b1;
      if (ps_spaces == 2'd0) begin
        if (c == CH_SP) begin
          ps_spaces = 2'd1;
        end else if (ps_mlen < METHOD_LEN) begin
          if (c != GET_TEXT[8 * (2 - int'(ps_mlen)) +: 8]) ps_mok = 1'b0;
          ps_mlen = ps_mlen + 3'd1;
        end else begin
          ps_mok  = 1'b0;
          ps_mlen = METHOD_OVF;
        end
      end else if (c == CH_SP && ps_spaces == 2'd1) begin
        ps_spaces = 2'd2;
      end
    end else if (ps_phase == PH_HDR) begin
      ps_text = 1'b1;
      if (!ps_colon) begin
        if (c == CH_COLON) begin
          ps_colon = 1'b1;
          if (ps_kok && ps_klen == KEY_LEN) ps_host = 1'b1;
        end else if (ps_klen < KEY_LEN) begin
          if (c != HOST_TEXT[8 * (3 - int'(ps_klen)) +: 8]) ps_kok = 1'b0;
          ps_klen = ps_klen + 3'd1;
        end else begin
          ps_kok  = 1'b0;
          ps_klen = KEY_OVF;
        end
      end
    end
  endtask

  task close_line();
    if (ps_phase == PH_REQ) begin
      if (!ps_text || ps_spaces < 2'd2) ps_err = OUT_BAD_LINE;
      else if (!(ps_mok && ps_mlen == METHOD_LEN)) ps_err = OUT_NOT_GET;
      else ps_phase = PH_HDR;
    end else if (ps_phase == PH_HDR) begin
      if (!ps_text) ps_phase = PH_IGNORE;
      else if (!ps_colon) ps_err = OUT_NO_COLON;
    end
    ps_text  = 1'b0;
    ps_colon = 1'b0;
    ps_klen  = 3'd0;
    ps_kok   = 1'b1;
  endtask

  task judge_byte(input logic [7:0] c, input logic fin, output logic got, output verdict_t v);
    got = 1'b0;
    v   = '0;
    if (ps_err == OUT_OK && ps_phase != PH_IGNORE) begin
      if (c == CH_CR) begin
        if (ps_cr) absorb_char(CH_CR);
        ps_cr = 1'b1;
      end else if (c == CH_LF && ps_cr) begin
        ps_cr = 1'b0;
        close_line();
      end else begin
        if (ps_cr) begin
          absorb_char(CH_CR);
          ps_cr = 1'b0;
        end
        absorb_char(c);
      end
    end
    if (fin) begin
      if (ps_err == OUT_OK && ps_phase != PH_IGNORE) begin
        if (ps_cr) begin
          absorb_char(CH_CR);
          ps_cr = 1'b0;
        end
        if (ps_text) close_line();
      end
      if (ps_err == OUT_OK && !ps_host) ps_err = OUT_NO_HOST;
      got        = 1'b1;
      v.accepted = (ps_err == OUT_OK);
      v.outcome  = ps_err;
      clear_parser();
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return CH_CR;
    if (r == 1) return CH_COLON;
    if (r == 2) return CH_SP;
    if (r == 3) return 8'($urandom);
    return 8'($urandom_range(33, 126));
  endfunction

  task append_byte(input logic [7:0] b);
    request_bytes = {request_bytes, b};
  endtask

  task add_text(input string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endtask

  task add_random(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) append_byte(pick_char());
  endtask

  task add_crlf();
    append_byte(CH_CR);
    append_byte(CH_LF);
  endtask

  task build_request();
    int  k;
    int  n_hdr;
    int  host_at;
    bit  frag;
    request_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) append_byte(8'($urandom));
      return;
    end
    case ($urandom_range(0, 9))
      0:       add_text("GE");
      1:       add_text("GETS");
      2:       add_text("get");
      3:       add_random(1, 4);
      default: add_text("GET");
    endcase
    k = $urandom_range(0, 19);
    if (k != 0) append_byte(CH_SP);
    add_random(0, 5);
    if (k > 1) append_byte(CH_SP);
    add_random(0, 6);
    if (k == 19) append_byte(CH_SP);
    n_hdr   = $urandom_range(0, 4);
    host_at = $urandom_range(0, 4);
    frag    = ($urandom_range(0, 5) == 0);
    for (int h = 0; h < n_hdr; h++) begin
      add_crlf();
      if (h == host_at) begin
        case ($urandom_range(0, 9))
          0:       add_text("Host");
          1:       add_text("HOS");
          2:       add_text("HOSTS");
          default: add_text("HOST");
        endcase
      end else begin
        repeat ($urandom_range(0, 6))
          append_byte(key_pool[$urandom_range(0, key_pool.len() - 1)]);
      end
      if ($urandom_range(0, 11) != 0) append_byte(CH_COLON);
      add_random(0, 6);
    end
    if (!frag) begin
      add_crlf();
      if ($urandom_range(0, 3) != 0) begin
        add_crlf();
        repeat ($urandom_range(0, 5)) append_byte(8'($urandom));
      end
    end
    if ($urandom_range(0, 19) == 0) append_byte(CH_CR);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin, input int typed);
    verdict_t v;
    logic     got;
    int       gap;
    in_valid   <= 1'b1;
    in_byte_in <= b;
    in_last    <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    judge_byte(b, fin, got, v);
    if (got) begin
      if (typed != PREDICT) begin
        v.outcome  = 3'(typed);
        v.accepted = (typed == OUT_OK);
      end
      pending_verdicts = {pending_verdicts, v};
      requests_sent++;
    end
    bytes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        rx_len = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        rx_len = pick_gap();
      end
      if (rx_len > 0) begin
        out_stall <= 1'b1;
        repeat (rx_len) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_valid && !out_stall) begin
      if (out_outcome <= OUT_NO_HOST) outcome_seen[out_outcome]++;
      if (pending_verdicts.size() == 0) begin
        $error("unexpected word: accepted %0d outcome %0d", out_accepted, out_outcome);
        errors++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (out_accepted !== exp_v.accepted) begin
          $error("accepted: expected %0d, got %0d", exp_v.accepted, out_accepted);
          errors++;
        end
        if (out_outcome !== exp_v.outcome) begin
          $error("outcome: expected %0d, got %0d", exp_v.outcome, out_outcome);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_byte_in <= 8'd0;
    in_last    <= 1'b0;
    clear_parser();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    steady = 1'b1;
    for (int r = 0; r < 8; r++) begin
      for (int i = 0; i < dir_text[r].len(); i++)
        send_byte(dir_text[r][i], i == dir_text[r].len() - 1, dir_code[r]);
    end
    steady = 1'b0;

    while (bytes_sent < 1300 || rnd_req < 40) begin
      if (rnd_req == 10) begin
        hold_off_cycles = 300;
        steady = 1'b1;
      end
      if (rnd_req == 18) steady = 1'b0;
      if (rnd_req == 25) drain();
      if (rnd_req == 30) steady = 1'b1;
      if (rnd_req == 35) steady = 1'b0;
      build_request();
      for (int i = 0; i < request_bytes.size(); i++)
        send_byte(request_bytes[i], i == request_bytes.size() - 1, PREDICT);
      rnd_req++;
    end

    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d bytes in %0d requests: malformed lines, lone CRs, noise, hold-off",
             bytes_sent, requests_sent);
    $display("verdicts: ok %0d, bad line %0d, not GET %0d, no colon %0d, no HOST %0d",
             outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
             outcome_seen[4]);
    if (errors == 0) begin
      $display("http_get_request_validator_tb passed");
    end else begin
      $display("http_get_request_validator_tb failed");
    end
    $finish;
  end

endmodule
